// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock once reset is released.
`define FIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true once reset is released.
`define FIC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/fic_pkg.sv =====
`default_nettype none

package fic_pkg;

    localparam int FRAC_BITS_DEF     = 12;
    localparam int CORDIC_STAGES_DEF = 16;

    // CORDIC datapath, Q4.30 angles and vectors
    localparam int ANG_W = 34;
    // cosine, Q14 signed
    localparam int COS_W = 17;
    // wide products, sums and divider operands
    localparam int NUM_W = 66;
    // quotient magnitude bits, up to the 2^30 limit
    localparam int QBITS = 31;
    localparam int Q_W   = QBITS + 1;

    // pipeline depth: five stages before the dividers, four after
    localparam int PRE_DIV  = 5;
    localparam int DIV_LAT  = QBITS + 2;
    localparam int POST_DIV = 4;

    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic signed [NUM_W-1:0] LIM     = NUM_W'(2**30);
    localparam logic signed [NUM_W-1:0] S16_MAX = NUM_W'(32767);
    localparam logic signed [NUM_W-1:0] S16_MIN = NUM_W'(-32768);

    // arctangent of 2^-i in Q30
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic neg;
        logic sat;
    } div_ctl_t;

    function automatic logic signed [Q_W-1:0] clamp_lim(input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W-1:0] r;
        r = v;
        if (v > LIM)
            r = LIM;
        else if (v < -LIM)
            r = -LIM;
        return r[Q_W-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W-1:0] r;
        r = v;
        if (v > S16_MAX)
            r = S16_MAX;
        else if (v < S16_MIN)
            r = S16_MIN;
        return r[15:0];
    endfunction

    function automatic int fic_latency(input int stages);
        return stages + PRE_DIV + DIV_LAT + POST_DIV;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fic_cordic_cell.sv =====
`default_nettype none

// One rotation-mode CORDIC micro-rotation, registered.
module fic_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic             clk,
    input  wire fic_pkg::cordic_t cin,
    output fic_pkg::cordic_t      cout
);

    fic_pkg::cordic_t stage_reg;
    fic_pkg::cordic_t stage_next;
    logic signed [fic_pkg::ANG_W-1:0] x, y, z, dx, dy, at;

    // rotate toward z = 0
    always_comb
    begin
        x  = cin.x;
        y  = cin.y;
        z  = cin.z;
        dx = y >>> IDX;
        dy = x >>> IDX;
        at = $signed({2'b00, fic_pkg::ATAN_Q30[IDX]});
        if (z >= 0)
        begin
            stage_next.x = x - dx;
            stage_next.y = y + dy;
            stage_next.z = z - at;
        end
        else
        begin
            stage_next.x = x + dx;
            stage_next.y = y - dy;
            stage_next.z = z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign cout = stage_reg;

endmodule

`default_nettype wire

// ===== rtl/fic_div_cell.sv =====
`default_nettype none

// One restoring-division step: decides quotient bit BIT.
module fic_div_cell #(
    parameter int BIT = 0,
    parameter int RW  = 98
) (
    input  wire logic                       clk,
    input  wire logic [RW-1:0]              rem_in,
    input  wire logic [fic_pkg::NUM_W-1:0]  den_in,
    input  wire logic [fic_pkg::QBITS-1:0]  quo_in,
    input  wire fic_pkg::div_ctl_t          ctl_in,
    output logic [RW-1:0]                   rem_out,
    output logic [fic_pkg::NUM_W-1:0]       den_out,
    output logic [fic_pkg::QBITS-1:0]       quo_out,
    output fic_pkg::div_ctl_t               ctl_out
);

    logic [RW-1:0]             dk;
    logic                      take;
    logic [RW-1:0]             rem_next, rem_reg;
    logic [fic_pkg::QBITS-1:0] quo_next, quo_reg;
    logic [fic_pkg::NUM_W-1:0] den_reg;
    fic_pkg::div_ctl_t         ctl_reg;

    // trial subtract of the shifted divisor
    always_comb
    begin
        dk       = RW'(den_in) << BIT;
        take     = !ctl_in.sat && (rem_in >= dk);
        rem_next = take ? (rem_in - dk) : rem_in;
        quo_next = quo_in | (take ? (fic_pkg::QBITS'(1) << BIT) : '0);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_in;
        ctl_reg <= ctl_in;
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
    assign ctl_out = ctl_reg;

endmodule

`default_nettype wire

// ===== rtl/fic_divider.sv =====
`default_nettype none

// Pipelined fractional divider: num * 2^FRAC_BITS / den, truncated toward
// zero, magnitude limited to 2^30. One operand pair per cycle.
module fic_divider #(
    parameter int FRAC_BITS = fic_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic signed [fic_pkg::NUM_W-1:0]  num,
    input  wire logic signed [fic_pkg::NUM_W-1:0]  den,
    output logic signed [fic_pkg::Q_W-1:0]         quo
);

    localparam int QB = fic_pkg::QBITS;
    localparam int RW = fic_pkg::NUM_W + ((FRAC_BITS > QB) ? FRAC_BITS : QB) + 1;

    logic [fic_pkg::NUM_W-1:0] mag_n, mag_d;
    logic [RW-1:0]             rem0;
    fic_pkg::div_ctl_t         ctl0;

    logic [RW-1:0]             rem_w [0:QB];
    logic [fic_pkg::NUM_W-1:0] den_w [0:QB];
    logic [QB-1:0]             quo_w [0:QB];
    fic_pkg::div_ctl_t         ctl_w [0:QB];

    logic [RW-1:0]             rem_reg;
    logic [fic_pkg::NUM_W-1:0] den_reg;
    fic_pkg::div_ctl_t         ctl_reg;

    logic [fic_pkg::Q_W-1:0]          qmag;
    logic signed [fic_pkg::Q_W-1:0]   quo_next, quo_reg;

    // signs off, scale numerator, early overflow check
    always_comb
    begin
        mag_n    = num[fic_pkg::NUM_W-1] ? fic_pkg::NUM_W'(-num) : fic_pkg::NUM_W'(num);
        mag_d    = den[fic_pkg::NUM_W-1] ? fic_pkg::NUM_W'(-den) : fic_pkg::NUM_W'(den);
        rem0     = RW'(mag_n) << FRAC_BITS;
        ctl0.neg = num[fic_pkg::NUM_W-1] ^ den[fic_pkg::NUM_W-1];
        ctl0.sat = rem0 >= (RW'(mag_d) << QB);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem0;
        den_reg <= mag_d;
        ctl_reg <= ctl0;
    end

    assign rem_w[0] = rem_reg;
    assign den_w[0] = den_reg;
    assign quo_w[0] = '0;
    assign ctl_w[0] = ctl_reg;

    // one quotient bit per cell, MSB first
    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        fic_div_cell #(
            .BIT (QB - 1 - k),
            .RW  (RW)
        ) u_cell (
            .clk     (clk),
            .rem_in  (rem_w[k]),
            .den_in  (den_w[k]),
            .quo_in  (quo_w[k]),
            .ctl_in  (ctl_w[k]),
            .rem_out (rem_w[k+1]),
            .den_out (den_w[k+1]),
            .quo_out (quo_w[k+1]),
            .ctl_out (ctl_w[k+1])
        );
    end

    // limit and restore sign
    always_comb
    begin
        qmag = {1'b0, quo_w[QB]};
        if (ctl_w[QB].sat || (qmag >= fic_pkg::Q_W'(2**30)))
            qmag = fic_pkg::Q_W'(2**30);
        quo_next = ctl_w[QB].neg ? -$signed(qmag) : $signed(qmag);
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

    // divisor pipeline tail is only needed for alignment of the last cell
    logic unused_den;
    assign unused_den = ^den_w[QB] ^ ^rem_w[QB];

endmodule

`default_nettype wire

// ===== rtl/fresnel_interface_coefficients.sv =====
// Fresnel coefficients at one interface between two absorbing media.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. busy stays low, so a new transaction may follow in every cycle.
// Each transaction carries the polarization, both complex indices (Q4.12)
// and the incident and refracted angles (Q2.13 radians).
// Result channel: done is high for one cycle with r, t, |r|^2, T, the power
// entering and the zero_divisor flag on the result ports in that cycle.
// From start to done a transaction passes through each CORDIC cell, the
// complex-product stages, the bit-per-cell dividers, and the stages for
// the power terms and output saturation.
// Throughput: one transaction per cycle; every cell and divider step is
// its own register stage.
// Reset clears only the valid pipeline; transactions in flight are dropped.
// The receiver cannot stall; results are presented exactly once.
`default_nettype none

module fresnel_interface_coefficients #(
    parameter int FRAC_BITS     = fic_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = fic_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               polarization,
    input  wire logic signed [15:0] n_i_re,
    input  wire logic signed [15:0] n_i_im,
    input  wire logic signed [15:0] n_f_re,
    input  wire logic signed [15:0] n_f_im,
    input  wire logic [14:0]        angle_in,
    input  wire logic [14:0]        angle_out,
    output logic                    done,
    output logic signed [15:0]      refl_re,
    output logic signed [15:0]      refl_im,
    output logic signed [15:0]      trans_re,
    output logic signed [15:0]      trans_im,
    output logic [14:0]             refl_power,
    output logic signed [15:0]      trans_power,
    output logic signed [15:0]      entering_power,
    output logic                    zero_divisor
);

    localparam int LAT = fic_pkg::fic_latency(CORDIC_STAGES);
    localparam int AW  = fic_pkg::ANG_W;
    localparam int CW  = fic_pkg::COS_W;
    localparam int NW  = fic_pkg::NUM_W;
    localparam int QW  = fic_pkg::Q_W;
    localparam int DL  = fic_pkg::DIV_LAT;

    typedef struct packed {
        logic               pol;
        logic signed [15:0] nir;
        logic signed [15:0] nii;
        logic signed [15:0] nfr;
        logic signed [15:0] nfi;
        logic               neg_i;
        logic               neg_f;
    } side_t;

    typedef struct packed {
        logic pol;
        logic zf;
    } flag_t;

    // valid pipeline
    logic [LAT-1:0] vld_reg, vld_next;

    assign vld_next = {vld_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    // angle fold about pi/2 and CORDIC seeds
    logic signed [AW-1:0] zi_raw, zf_raw;
    fic_pkg::cordic_t     chain_i [0:CORDIC_STAGES];
    fic_pkg::cordic_t     chain_f [0:CORDIC_STAGES];
    side_t                side_next;

    always_comb
    begin
        zi_raw            = $signed({2'b00, angle_in, 17'b0});
        zf_raw            = $signed({2'b00, angle_out, 17'b0});
        side_next.pol     = polarization;
        side_next.nir     = n_i_re;
        side_next.nii     = n_i_im;
        side_next.nfr     = n_f_re;
        side_next.nfi     = n_f_im;
        side_next.neg_i   = zi_raw > fic_pkg::HALF_PI_Q30;
        side_next.neg_f   = zf_raw > fic_pkg::HALF_PI_Q30;
        chain_i[0].x      = fic_pkg::GAIN_Q30;
        chain_i[0].y      = '0;
        chain_i[0].z      = side_next.neg_i ? (fic_pkg::PI_Q30 - zi_raw) : zi_raw;
        chain_f[0].x      = fic_pkg::GAIN_Q30;
        chain_f[0].y      = '0;
        chain_f[0].z      = side_next.neg_f ? (fic_pkg::PI_Q30 - zf_raw) : zf_raw;
    end

    // two CORDIC rows
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        fic_cordic_cell #(.IDX(k)) u_cell_i (
            .clk  (clk),
            .cin  (chain_i[k]),
            .cout (chain_i[k+1])
        );
        fic_cordic_cell #(.IDX(k)) u_cell_f (
            .clk  (clk),
            .cin  (chain_f[k]),
            .cout (chain_f[k+1])
        );
    end

    // sideband travels next to the CORDIC rows
    side_t side_reg [CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < CORDIC_STAGES; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // P1: round cosines to Q14 and apply fold sign
    side_t                side1_reg;
    logic signed [CW-1:0] ci_reg, cf_reg, ci_next, cf_next;
    logic signed [AW-1:0] xi_rnd, xf_rnd;

    always_comb
    begin
        xi_rnd  = (chain_i[CORDIC_STAGES].x + AW'(32768)) >>> 16;
        xf_rnd  = (chain_f[CORDIC_STAGES].x + AW'(32768)) >>> 16;
        ci_next = side_reg[CORDIC_STAGES-1].neg_i ? -xi_rnd[CW-1:0] : xi_rnd[CW-1:0];
        cf_next = side_reg[CORDIC_STAGES-1].neg_f ? -xf_rnd[CW-1:0] : xf_rnd[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_reg[CORDIC_STAGES-1];
        ci_reg    <= ci_next;
        cf_reg    <= cf_next;
    end

    // P2: index times cosine
    logic signed [32:0] t_air, t_aii, t_afr, t_afi, t_br, t_bi, t_er, t_ei;
    logic signed [31:0] air2_reg, aii2_reg, afr2_reg, afi2_reg;
    logic signed [31:0] br2_reg, bi2_reg, er2_reg, ei2_reg;
    logic               pol2_reg;

    always_comb
    begin
        t_air = side1_reg.nir * ci_reg;
        t_aii = side1_reg.nii * ci_reg;
        t_afr = side1_reg.nfr * cf_reg;
        t_afi = side1_reg.nfi * cf_reg;
        t_br  = side1_reg.nfr * ci_reg;
        t_bi  = side1_reg.nfi * ci_reg;
        t_er  = side1_reg.nir * cf_reg;
        t_ei  = side1_reg.nii * cf_reg;
    end

    always_ff @(posedge clk)
    begin
        air2_reg <= t_air[31:0];
        aii2_reg <= t_aii[31:0];
        afr2_reg <= t_afr[31:0];
        afi2_reg <= t_afi[31:0];
        br2_reg  <= t_br[31:0];
        bi2_reg  <= t_bi[31:0];
        er2_reg  <= t_er[31:0];
        ei2_reg  <= t_ei[31:0];
        pol2_reg <= side1_reg.pol;
    end

    // P3: numerator and denominator of r, zero check
    logic signed [32:0] nr_next, ni_next, dr_next, di_next;
    logic signed [32:0] nr3_reg, ni3_reg, dr3_reg, di3_reg;
    logic signed [31:0] air3_reg, aii3_reg, afr3_reg;
    logic               zf_next, zf3_reg, pol3_reg;

    always_comb
    begin
        if (pol2_reg)
        begin
            nr_next = 33'(br2_reg) - 33'(er2_reg);
            ni_next = 33'(bi2_reg) - 33'(ei2_reg);
            dr_next = 33'(br2_reg) + 33'(er2_reg);
            di_next = 33'(bi2_reg) + 33'(ei2_reg);
        end
        else
        begin
            nr_next = 33'(air2_reg) - 33'(afr2_reg);
            ni_next = 33'(aii2_reg) - 33'(afi2_reg);
            dr_next = 33'(air2_reg) + 33'(afr2_reg);
            di_next = 33'(aii2_reg) + 33'(afi2_reg);
        end
        zf_next = ((dr_next == 0) && (di_next == 0)) || (air2_reg == 0);
    end

    always_ff @(posedge clk)
    begin
        nr3_reg  <= nr_next;
        ni3_reg  <= ni_next;
        dr3_reg  <= dr_next;
        di3_reg  <= di_next;
        air3_reg <= air2_reg;
        aii3_reg <= aii2_reg;
        afr3_reg <= afr2_reg;
        zf3_reg  <= zf_next;
        pol3_reg <= pol2_reg;
    end

    // P4: cross products
    logic signed [NW-1:0] m_dd_r, m_dd_i, m_a, m_b, m_c, m_d, m_e, m_f, m_g, m_h;
    logic signed [NW-1:0] dd_r4_reg, dd_i4_reg, a4_reg, b4_reg, c4_reg, d4_reg;
    logic signed [NW-1:0] e4_reg, f4_reg, g4_reg, h4_reg;
    logic signed [31:0]   air4_reg, aii4_reg, afr4_reg;
    logic                 zf4_reg, pol4_reg;

    always_comb
    begin
        m_dd_r = dr3_reg * dr3_reg;
        m_dd_i = di3_reg * di3_reg;
        m_a    = nr3_reg * dr3_reg;
        m_b    = ni3_reg * di3_reg;
        m_c    = ni3_reg * dr3_reg;
        m_d    = nr3_reg * di3_reg;
        m_e    = air3_reg * dr3_reg;
        m_f    = aii3_reg * di3_reg;
        m_g    = aii3_reg * dr3_reg;
        m_h    = air3_reg * di3_reg;
    end

    always_ff @(posedge clk)
    begin
        dd_r4_reg <= m_dd_r;
        dd_i4_reg <= m_dd_i;
        a4_reg    <= m_a;
        b4_reg    <= m_b;
        c4_reg    <= m_c;
        d4_reg    <= m_d;
        e4_reg    <= m_e;
        f4_reg    <= m_f;
        g4_reg    <= m_g;
        h4_reg    <= m_h;
        air4_reg  <= air3_reg;
        aii4_reg  <= aii3_reg;
        afr4_reg  <= afr3_reg;
        zf4_reg   <= zf3_reg;
        pol4_reg  <= pol3_reg;
    end

    // P5: divider operands
    logic signed [NW-1:0] den5_reg, nrr5_reg, nri5_reg, ntr5_reg, nti5_reg;
    logic signed [NW-1:0] air5_reg, aii5_reg, afr5_reg;
    flag_t                flag5_reg;

    always_ff @(posedge clk)
    begin
        den5_reg      <= dd_r4_reg + dd_i4_reg;
        nrr5_reg      <= a4_reg + b4_reg;
        nri5_reg      <= c4_reg - d4_reg;
        ntr5_reg      <= (e4_reg + f4_reg) <<< 1;
        nti5_reg      <= (g4_reg - h4_reg) <<< 1;
        air5_reg      <= NW'(air4_reg);
        aii5_reg      <= NW'(aii4_reg);
        afr5_reg      <= NW'(afr4_reg);
        flag5_reg.pol <= pol4_reg;
        flag5_reg.zf  <= zf4_reg;
    end

    // six dividers side by side
    logic signed [QW-1:0] q_rr, q_ri, q_tr, q_ti, q_t, q_a;

    fic_divider #(.FRAC_BITS(FRAC_BITS)) u_div_rr (
        .clk (clk), .num (nrr5_reg), .den (den5_reg), .quo (q_rr)
    );
    fic_divider #(.FRAC_BITS(FRAC_BITS)) u_div_ri (
        .clk (clk), .num (nri5_reg), .den (den5_reg), .quo (q_ri)
    );
    fic_divider #(.FRAC_BITS(FRAC_BITS)) u_div_tr (
        .clk (clk), .num (ntr5_reg), .den (den5_reg), .quo (q_tr)
    );
    fic_divider #(.FRAC_BITS(FRAC_BITS)) u_div_ti (
        .clk (clk), .num (nti5_reg), .den (den5_reg), .quo (q_ti)
    );
    fic_divider #(.FRAC_BITS(FRAC_BITS)) u_div_t (
        .clk (clk), .num (afr5_reg), .den (air5_reg), .quo (q_t)
    );
    fic_divider #(.FRAC_BITS(FRAC_BITS)) u_div_a (
        .clk (clk), .num (aii5_reg), .den (air5_reg), .quo (q_a)
    );

    // flags ride along with the dividers
    flag_t dflag_reg [DL];

    always_ff @(posedge clk)
    begin
        dflag_reg[0] <= flag5_reg;
        for (int k = 1; k < DL; k++)
            dflag_reg[k] <= dflag_reg[k-1];
    end

    // Q1: squares and the ratio product
    logic signed [63:0]   rr2_next, ri2_next, tr2_next, ti2_next, rat_next;
    logic signed [63:0]   rr2_q1_reg, ri2_q1_reg, tr2_q1_reg, ti2_q1_reg, ratp_q1_reg;
    logic signed [QW-1:0] rr_q1_reg, ri_q1_reg, tr_q1_reg, ti_q1_reg, qt_q1_reg;
    flag_t                flag_q1_reg;

    always_comb
    begin
        rr2_next = q_rr * q_rr;
        ri2_next = q_ri * q_ri;
        tr2_next = q_tr * q_tr;
        ti2_next = q_ti * q_ti;
        rat_next = q_ri * q_a;
    end

    always_ff @(posedge clk)
    begin
        rr2_q1_reg  <= rr2_next;
        ri2_q1_reg  <= ri2_next;
        tr2_q1_reg  <= tr2_next;
        ti2_q1_reg  <= ti2_next;
        ratp_q1_reg <= rat_next;
        rr_q1_reg   <= q_rr;
        ri_q1_reg   <= q_ri;
        tr_q1_reg   <= q_tr;
        ti_q1_reg   <= q_ti;
        qt_q1_reg   <= q_t;
        flag_q1_reg <= dflag_reg[DL-1];
    end

    // Q2: scale back to FRAC_BITS and limit
    logic signed [QW-1:0] rp_q2_reg, tsq_q2_reg, rat_q2_reg;
    logic signed [QW-1:0] rr_q2_reg, ri_q2_reg, tr_q2_reg, ti_q2_reg, qt_q2_reg;
    flag_t                flag_q2_reg;

    always_ff @(posedge clk)
    begin
        rp_q2_reg   <= fic_pkg::clamp_lim((NW'(rr2_q1_reg) + NW'(ri2_q1_reg)) >>> FRAC_BITS);
        tsq_q2_reg  <= fic_pkg::clamp_lim((NW'(tr2_q1_reg) + NW'(ti2_q1_reg)) >>> FRAC_BITS);
        rat_q2_reg  <= fic_pkg::clamp_lim(NW'(ratp_q1_reg) >>> FRAC_BITS);
        rr_q2_reg   <= rr_q1_reg;
        ri_q2_reg   <= ri_q1_reg;
        tr_q2_reg   <= tr_q1_reg;
        ti_q2_reg   <= ti_q1_reg;
        qt_q2_reg   <= qt_q1_reg;
        flag_q2_reg <= flag_q1_reg;
    end

    // Q3: transmitted power product, entering power
    logic signed [NW-1:0] rat2, ep_next;
    logic signed [63:0]   tpp_next, tpp_q3_reg;
    logic signed [33:0]   ep_q3_reg;
    logic signed [QW-1:0] rp_q3_reg, rr_q3_reg, ri_q3_reg, tr_q3_reg, ti_q3_reg;
    logic                 zf_q3_reg;

    always_comb
    begin
        tpp_next = tsq_q2_reg * qt_q2_reg;
        rat2     = NW'(rat_q2_reg) <<< 1;
        ep_next  = (NW'(1) <<< FRAC_BITS) - NW'(rp_q2_reg)
                   + (flag_q2_reg.pol ? -rat2 : rat2);
    end

    always_ff @(posedge clk)
    begin
        tpp_q3_reg <= tpp_next;
        ep_q3_reg  <= ep_next[33:0];
        rp_q3_reg  <= rp_q2_reg;
        rr_q3_reg  <= rr_q2_reg;
        ri_q3_reg  <= ri_q2_reg;
        tr_q3_reg  <= tr_q2_reg;
        ti_q3_reg  <= ti_q2_reg;
        zf_q3_reg  <= flag_q2_reg.zf;
    end

    // Q4: saturate to the port formats, zero on a singular denominator
    logic signed [QW-1:0] tp_val;
    logic [15:0]          rre_next, rim_next, tre_next, tim_next, tpw_next, epw_next;
    logic [14:0]          rpw_next;
    logic [15:0]          rre_reg, rim_reg, tre_reg, tim_reg, tpw_reg, epw_reg;
    logic [14:0]          rpw_reg;
    logic                 zd_reg;

    always_comb
    begin
        tp_val   = fic_pkg::clamp_lim(NW'(tpp_q3_reg) >>> FRAC_BITS);
        rre_next = fic_pkg::sat16(NW'(rr_q3_reg));
        rim_next = fic_pkg::sat16(NW'(ri_q3_reg));
        tre_next = fic_pkg::sat16(NW'(tr_q3_reg));
        tim_next = fic_pkg::sat16(NW'(ti_q3_reg));
        tpw_next = fic_pkg::sat16(NW'(tp_val));
        epw_next = fic_pkg::sat16(NW'(ep_q3_reg));
        rpw_next = (rp_q3_reg > QW'(32767)) ? 15'h7FFF : rp_q3_reg[14:0];
        if (zf_q3_reg)
        begin
            rre_next = '0;
            rim_next = '0;
            tre_next = '0;
            tim_next = '0;
            tpw_next = '0;
            epw_next = '0;
            rpw_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rre_reg <= rre_next;
        rim_reg <= rim_next;
        tre_reg <= tre_next;
        tim_reg <= tim_next;
        tpw_reg <= tpw_next;
        epw_reg <= epw_next;
        rpw_reg <= rpw_next;
        zd_reg  <= zf_q3_reg;
    end

    assign refl_re        = rre_reg;
    assign refl_im        = rim_reg;
    assign trans_re       = tre_reg;
    assign trans_im       = tim_reg;
    assign refl_power     = rpw_reg;
    assign trans_power    = tpw_reg;
    assign entering_power = epw_reg;
    assign zero_divisor   = zd_reg;

endmodule

`default_nettype wire

// ===== rtl/fic_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the Fresnel block.
module fic_checker #(
    parameter int CORDIC_STAGES = fic_pkg::CORDIC_STAGES_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [15:0] refl_re,
    input wire logic signed [15:0] refl_im,
    input wire logic signed [15:0] trans_re,
    input wire logic signed [15:0] trans_im,
    input wire logic [14:0]        refl_power,
    input wire logic signed [15:0] trans_power,
    input wire logic signed [15:0] entering_power,
    input wire logic               zero_divisor
);

    localparam int LAT = fic_pkg::fic_latency(CORDIC_STAGES);

    // all numeric result fields are zero
    logic all_zero;

    assign all_zero = (refl_re == 16'sd0) && (refl_im == 16'sd0)
                      && (trans_re == 16'sd0) && (trans_im == 16'sd0)
                      && (refl_power == 15'd0) && (trans_power == 16'sd0)
                      && (entering_power == 16'sd0);

    // the pipeline never pushes back
    `FIC_NEVER(a_never_busy, busy, "busy raised on a fully pipelined block")

    // every transaction comes out after the fixed latency
    `FIC_ASSERT(a_lat_fwd, start |-> ##LAT done, "transaction result missing")

    // no result without a matching transaction
    `FIC_ASSERT(a_lat_bwd, done |-> $past(start, LAT), "result without a transaction")

    // singular denominator forces every numeric result to zero
    `FIC_ASSERT(a_zero_out, done && zero_divisor |-> all_zero, "nonzero result with zero_divisor")

endmodule

bind fresnel_interface_coefficients fic_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_fic_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .refl_re        (refl_re),
    .refl_im        (refl_im),
    .trans_re       (trans_re),
    .trans_im       (trans_im),
    .refl_power     (refl_power),
    .trans_power    (trans_power),
    .entering_power (entering_power),
    .zero_divisor   (zero_divisor)
);

`default_nettype wire
